// ===== src/kie_pkg.sv =====
// kie_pkg: shared types and constants of the keyframe interpolation engine
// no dependencies
`default_nettype none
package kie_pkg;
  localparam int NUM_CHANNELS_DEF = 8;
  localparam int MAX_KEYS_DEF = 8;

  typedef enum logic [2:0] {
    REQ_WRITE = 3'd0,
    REQ_INIT  = 3'd1,
    REQ_PLAY  = 3'd2,
    REQ_STOP  = 3'd3,
    REQ_TICK  = 3'd4
  } req_t;

  // start and result of a signed 64 / unsigned 17 bit division
  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic [16:0]        den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== src/kie_ram.sv =====
// kie_ram: generic single port synchronous ram, registered read
// no dependencies
`default_nettype none
module kie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== src/kie_div.sv =====
// kie_div: restoring divider, one quotient bit per cycle, truncates toward zero
// depends on kie_pkg
`default_nettype none
module kie_div
  import kie_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic        neg;
  logic [63:0] quo;
  logic [16:0] rem;
  logic [16:0] den;
  logic [17:0] trial;
  logic [63:0] mag;
  logic signed [63:0] quo_s;

  assign mag = req.num[63] ? 64'(-req.num) : 64'(req.num);
  assign trial = {rem, quo[63]} - {1'b0, den};
  assign quo_s = neg ? -$signed(quo) : $signed(quo);
  assign rsp = {done, quo_s};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= '0;
        neg <= req.num[63];
        quo <= mag;
        rem <= '0;
        den <= req.den;
      end else if (busy) begin
        if (!trial[17]) begin
          rem <= trial[16:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[15:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/keyframe_interpolation_engine.sv =====
// keyframe_interpolation_engine: per-channel keyframe tracks, linear interpolation
// depends on kie_pkg, kie_ram, kie_div
// requests: write/init/play/stop are handled in S_IDLE; a tick scans the key slots of each playing
//   channel, divides when it interpolates, steps over idle channels and waits on output stalls
// one request at a time: in_stall holds off requests until a tick is done and its output taken
// reset: synchronous; clears channel state, then sweeps every slot word to zero
`default_nettype none
module keyframe_interpolation_engine
  import kie_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         req_type,
  input  wire logic [2:0]         anim_index,
  input  wire logic [2:0]         key_slot,
  input  wire logic [15:0]        key_frame,
  input  wire logic signed [31:0] key_value,
  input  wire logic               key_valid,
  input  wire logic               cycle_flag,
  input  wire logic signed [31:0] start_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_channel,
  output logic signed [31:0]      out_value,
  output logic                    last_in_run
);
  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int SD = NUM_CHANNELS * MAX_KEYS;
  localparam int SW = $clog2(SD) > 0 ? $clog2(SD) : 1;
  localparam int SWD = 49; // in_use, frame, value
  localparam int CWD = 49; // value, counter, loop

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_NEXT  = 8'b00000100,
    S_CHAN  = 8'b00001000,
    S_SCAN  = 8'b00010000,
    S_CALC  = 8'b00100000,
    S_DIV   = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state;

  // slot memory: {in_use, frame, value}
  logic           sm_we;
  logic [SW-1:0]  sm_addr;
  logic [SWD-1:0] sm_wdata, sm_rdata;
  // channel memory: {value, counter, loop}
  logic           cm_we;
  logic [CW-1:0]  cm_addr;
  logic [CWD-1:0] cm_wdata, cm_rdata;

  kie_ram #(.WIDTH(SWD), .DEPTH(SD)) u_slots (
    .clk(clk), .we(sm_we), .addr(sm_addr), .wdata(sm_wdata), .rdata(sm_rdata));
  kie_ram #(.WIDTH(CWD), .DEPTH(NUM_CHANNELS)) u_chans (
    .clk(clk), .we(cm_we), .addr(cm_addr), .wdata(cm_wdata), .rdata(cm_rdata));

  div_req_t dreq;
  div_rsp_t drsp;
  kie_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // channel-memory contents are not reset, so track which are initialized
  logic [NUM_CHANNELS-1:0] ch_ok;

  logic [SW-1:0]  clr_idx;
  logic [CW:0]    ch;        // tick channel cursor, one wider for end test
  logic [KW:0]    rd_slot;   // slot address cursor
  logic [KW:0]    rcv_cnt;   // slot words received
  logic           have_prev, have_next, any;
  logic [15:0]    pf, nf, last;
  logic signed [31:0] pv, nv;
  logic signed [31:0] cval;
  logic [15:0]    ccnt;
  logic           cloop;
  logic [CW-1:0]  res_ch;
  logic signed [31:0] res_val;
  logic           res_pend;
  logic signed [32:0] diff;
  logic signed [63:0] prod;
  logic           more_play;

  // request decode
  req_t rq;
  assign rq = req_t'(req_type);
  logic ch_in_range, slot_in_range;
  assign ch_in_range = 32'(anim_index) < NUM_CHANNELS;
  assign slot_in_range = 32'(key_slot) < MAX_KEYS;

  assign in_stall = (state != S_IDLE) || out_valid;

  logic acc;
  assign acc = in_valid && !in_stall;

  // output register loads when empty or being drained
  logic out_load;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  // current slot word
  logic        s_use;
  logic [15:0] s_frame;
  logic signed [31:0] s_val;
  assign {s_use, s_frame, s_val} = sm_rdata;

  // channel word, reset value when never initialized
  logic signed [31:0] m_val;
  logic [15:0] m_cnt;
  logic m_loop;
  assign {m_val, m_cnt, m_loop} = cm_rdata;

  // saturated final value
  logic signed [63:0] sum;
  logic signed [31:0] sat;
  assign sum = 64'(pv) + drsp.quo;
  assign sat = (sum > 64'sd2147483647) ? 32'sh7fffffff :
               (sum < -64'sd2147483648) ? 32'sh80000000 : sum[31:0];

  always_comb begin
    sm_we = 1'b0;
    sm_addr = SW'({anim_index[CW-1:0], key_slot[KW-1:0]} & {SW{1'b1}});
    sm_wdata = {key_valid, key_frame, key_value};
    if (state == S_CLEAR) begin
      sm_we = 1'b1;
      sm_addr = clr_idx;
      sm_wdata = '0;
    end else if (state == S_SCAN || state == S_CHAN) begin
      sm_addr = SW'(32'(ch[CW-1:0]) * MAX_KEYS + 32'(rd_slot[KW-1:0]));
    end else if (acc && rq == REQ_WRITE && ch_in_range && slot_in_range) begin
      sm_we = 1'b1;
      sm_addr = SW'(32'(anim_index) * MAX_KEYS + 32'(key_slot));
    end
  end

  // more playing channels after the current one (in flop copy)
  logic [NUM_CHANNELS-1:0] play_bits;
  always_comb begin
    more_play = 1'b0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (i > 32'(ch) && play_bits[i]) more_play = 1'b1;
    end
  end

  always_comb begin
    cm_we = 1'b0;
    cm_addr = ch[CW-1:0];
    cm_wdata = '0;
    if (state == S_IDLE && acc && ch_in_range) begin
      cm_addr = anim_index[CW-1:0];
      unique case (rq)
        REQ_INIT: begin
          cm_we = 1'b1;
          cm_wdata = {start_value, 16'd0, cycle_flag};
        end
        default: ;
      endcase
    end else if (state == S_OUT && !res_pend) begin
      cm_we = 1'b1;
      cm_wdata = {res_val,
                  (ccnt >= last) ? 16'd0 : ccnt + 16'd1,
                  cloop};
    end
  end

  // before the first keyframe the start point is the current property
  assign diff = 33'(nv) - 33'(have_prev ? pv : cval);

  always_ff @(posedge clk) begin
    dreq.start <= !rst && (state == S_DIV) && res_pend;
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      ch_ok <= '0;
      play_bits <= '0;
      out_valid <= 1'b0;
      res_pend <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + SW'(1);
          if (32'(clr_idx) == SD - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (acc) begin
            if (rq == REQ_TICK) begin
              ch <= '0;
              state <= S_NEXT;
            end else if (ch_in_range) begin
              if (rq == REQ_INIT) begin
                ch_ok[anim_index[CW-1:0]] <= 1'b1;
                play_bits[anim_index[CW-1:0]] <= 1'b0;
              end else if (rq == REQ_PLAY) begin
                play_bits[anim_index[CW-1:0]] <= 1'b1;
              end else if (rq == REQ_STOP) begin
                play_bits[anim_index[CW-1:0]] <= 1'b0;
              end
            end
          end
        end
        S_NEXT: begin
          // find next playing channel
          if (32'(ch) >= NUM_CHANNELS) begin
            state <= S_IDLE;
          end else if (play_bits[ch[CW-1:0]]) begin
            rd_slot <= '0;
            state <= S_CHAN;
          end else begin
            ch <= ch + 1'b1;
          end
        end
        S_CHAN: begin
          // memory read of channel word issued last cycle
          rd_slot <= rd_slot + 1'b1;
          rcv_cnt <= '0;
          have_prev <= 1'b0;
          have_next <= 1'b0;
          any <= 1'b0;
          last <= '0;
          state <= S_SCAN;
          cval <= ch_ok[ch[CW-1:0]] ? m_val : '0;
          ccnt <= ch_ok[ch[CW-1:0]] ? m_cnt : '0;
          cloop <= ch_ok[ch[CW-1:0]] ? m_loop : 1'b0;
        end
        S_SCAN: begin
          if (32'(rd_slot) < MAX_KEYS) rd_slot <= rd_slot + 1'b1;
          rcv_cnt <= rcv_cnt + 1'b1;
          if (s_use) begin
            if (!any || s_frame > last) last <= s_frame;
            any <= 1'b1;
            if (s_frame <= ccnt) begin
              if (!have_prev || s_frame > pf) begin
                pf <= s_frame; pv <= s_val; have_prev <= 1'b1;
              end
            end else if (!have_next || s_frame < nf) begin
              nf <= s_frame; nv <= s_val; have_next <= 1'b1;
            end
          end
          if (32'(rcv_cnt) == MAX_KEYS - 1) state <= S_CALC;
        end
        S_CALC: begin
          if (!have_prev) begin
            pf <= '0;
            pv <= cval;
          end
          if (!any) begin
            res_val <= cval;
            state <= S_OUT;
          end else if (!have_next) begin
            res_val <= have_prev ? pv : cval;
            state <= S_OUT;
          end else begin
            prod <= 64'(diff) * $signed({1'b0, ccnt - (have_prev ? pf : 16'd0)});
            if (!have_prev) begin
              dreq.den <= {1'b0, nf};
            end else begin
              dreq.den <= 17'(nf) - 17'(pf);
            end
            state <= S_DIV;
            res_pend <= 1'b1;
          end
          res_ch <= ch[CW-1:0];
        end
        S_DIV: begin
          if (res_pend) begin
            dreq.num <= prod;
            res_pend <= 1'b0;
          end else if (drsp.done) begin
            res_val <= sat;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_channel <= 3'(res_ch);
            out_value <= res_val;
            // last word of the tick when no later channel plays
            last_in_run <= !more_play;
            ch_ok[ch[CW-1:0]] <= 1'b1;
            if (ccnt >= last && !cloop) play_bits[ch[CW-1:0]] <= 1'b0;
            ch <= ch + 1'b1;
            state <= S_NEXT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the result must never be presented before the divider finished
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && !drsp.done) |=> !(out_valid && $rose(out_valid)) || $past(state) != S_DIV)
    else $error("result left before division done");
  // no request is taken while a result waits
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request accepted while result pending");
  // the clearing sweep runs only right after reset
  assert property (@(posedge clk) disable iff (rst)
    (state != S_CLEAR) |=> (state != S_CLEAR))
    else $error("clear sweep reentered");
endmodule
`default_nettype wire
